FILE: hw/rtl/thi_pkg.sv
// ----------------------------------------------------------------------------
// thi_pkg
// Shared types, codes and constants of the terrain height interpolator.
// ----------------------------------------------------------------------------
package thi_pkg;

  localparam int GRID_POINTS_DEF = 256;
  localparam int ADDR_W          = 16;
  localparam int STORE_DEPTH     = 1 << ADDR_W;
  localparam int HEIGHT_W        = 16;
  localparam int FRAC_W          = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int HALF_EXT_W      = 31;
  localparam int SCALE_W         = 32;
  localparam int POINTS_W        = 9;

  localparam logic [FRAC_W:0] ONE_Q16 = 17'h1_0000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_POINTS = 2'd2;

  localparam logic [HALF_EXT_W-1:0] HALF_EXTENT_RST = 31'd6553600;
  localparam logic [SCALE_W-1:0]    GRID_SCALE_RST  = 32'd83558;
  localparam logic [POINTS_W-1:0]   GRID_POINTS_RST = 9'd256;

  typedef struct packed {
    logic [ADDR_W-1:0] a00;
    logic [ADDR_W-1:0] a10;
    logic [ADDR_W-1:0] a01;
    logic [ADDR_W-1:0] a11;
  } quad_addr_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] h00;
    logic [HEIGHT_W-1:0] h10;
    logic [HEIGHT_W-1:0] h01;
    logic [HEIGHT_W-1:0] h11;
  } quad_height_t;

endpackage

FILE: hw/rtl/thi_height_store.sv
// ----------------------------------------------------------------------------
// thi_height_store
// Height table held in two identical banks, each with one write port and two
// read ports, so that all four corners of a cell are read together.
// ----------------------------------------------------------------------------
module thi_height_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [thi_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [thi_pkg::HEIGHT_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  thi_pkg::quad_addr_t           rd_addr,
  output thi_pkg::quad_height_t         rd_data
);

  logic [thi_pkg::HEIGHT_W-1:0] bank_a_r [0:thi_pkg::STORE_DEPTH-1];
  logic [thi_pkg::HEIGHT_W-1:0] bank_b_r [0:thi_pkg::STORE_DEPTH-1];
  thi_pkg::quad_height_t        rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_a_r[wr_addr] <= wr_data;
      bank_b_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r.h00 <= bank_a_r[rd_addr.a00];
      rd_data_r.h10 <= bank_a_r[rd_addr.a10];
      rd_data_r.h01 <= bank_b_r[rd_addr.a01];
      rd_data_r.h11 <= bank_b_r[rd_addr.a11];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/terrain_height_interpolator_unit.sv
// ----------------------------------------------------------------------------
// terrain_height_interpolator_unit
// Heightmap lookup: loads a square grid of heights and returns the height at a
// world position, interpolated over the triangle of the cell that holds it.
//
//   channel   ports                                     handshake
//   input     in_op, in_load_*, in_world_x/z            start && !busy
//   result    out_terrain_height, out_on_terrain        out_valid, one cycle
//   config    cfg_index, cfg_wdata                      cfg_we
//
// One item is taken every cycle; busy stays low and the receiver never stalls.
// Eight register stages (capture, offset, multiply, bounds, cell index, table
// read, weight products, final sum) carry each query to its result. A load
// writes the table as it leaves the cell index stage and gives no result.
// Reset clears the valid bits and restores the config registers; the table holds no reset value.
// ----------------------------------------------------------------------------
module terrain_height_interpolator_unit #(
  parameter int GRID_POINTS = thi_pkg::GRID_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [thi_pkg::ADDR_W-1:0]           in_load_index,
  input  logic [thi_pkg::HEIGHT_W-1:0]         in_load_height,
  input  logic signed [31:0]                   in_world_x,
  input  logic signed [31:0]                   in_world_z,
  output logic                                 out_valid,
  output logic [thi_pkg::HEIGHT_W-1:0]         out_terrain_height,
  output logic                                 out_on_terrain,
  input  logic                                 cfg_we,
  input  logic [thi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [thi_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int PW  = $clog2(GRID_POINTS + 1);
  localparam int CW  = $clog2(GRID_POINTS - 1);
  localparam int AW  = thi_pkg::ADDR_W;
  localparam int HW  = thi_pkg::HEIGHT_W;
  localparam int FW  = thi_pkg::FRAC_W;
  localparam int LAT = 8;

  logic [thi_pkg::HALF_EXT_W-1:0] half_extent_r;
  logic [thi_pkg::SCALE_W-1:0]    grid_scale_r;
  logic [thi_pkg::POINTS_W-1:0]   grid_points_r;
  logic [PW-1:0]                  pts;

  logic accept;

  // Stage 1: captured item.
  logic               s1_valid_r, s1_op_r;
  logic [AW-1:0]      s1_lidx_r;
  logic [HW-1:0]      s1_lhgt_r;
  logic signed [31:0] s1_wx_r, s1_wz_r;
  // Stage 2: offset magnitudes.
  logic               s2_valid_r, s2_op_r;
  logic [AW-1:0]      s2_lidx_r;
  logic [HW-1:0]      s2_lhgt_r;
  logic [31:0]        s2_magx_r, s2_magz_r;
  logic               s2_negx_r, s2_negz_r;
  logic signed [32:0] tx_nxt, tz_nxt, ntx_nxt, ntz_nxt;
  // Stage 3: grid coordinates.
  logic               s3_valid_r, s3_op_r;
  logic [AW-1:0]      s3_lidx_r;
  logic [HW-1:0]      s3_lhgt_r;
  logic [47:0]        s3_gx_r, s3_gz_r;
  logic               s3_offx_r, s3_offz_r;
  logic [63:0]        px_nxt, pz_nxt;
  // Stage 4: cell and fraction.
  logic               s4_valid_r, s4_op_r, s4_on_r;
  logic [AW-1:0]      s4_lidx_r;
  logic [HW-1:0]      s4_lhgt_r;
  logic [CW-1:0]      s4_cx_r, s4_cz_r;
  logic [FW-1:0]      s4_fx_r, s4_fz_r;
  logic               onx_nxt, onz_nxt;
  // Stage 5: table index.
  logic               s5_valid_r, s5_op_r, s5_on_r;
  logic [AW-1:0]      s5_lidx_r;
  logic [HW-1:0]      s5_lhgt_r;
  logic [AW-1:0]      s5_base_r;
  logic [FW-1:0]      s5_fx_r, s5_fz_r;
  logic [31:0]        base_nxt;
  // Stage 6: corner heights in the store output register.
  logic               s6_valid_r, s6_on_r;
  logic [FW-1:0]      s6_fx_r, s6_fz_r;
  // Stage 7: weighted products.
  logic               s7_valid_r, s7_on_r;
  logic signed [34:0] s7_p1_r, s7_p2_r, s7_p3_r;
  logic [HW-1:0]      s7_base_r;
  // Output stage.
  logic               out_valid_r, out_on_r;
  logic [HW-1:0]      out_height_r;

  thi_pkg::quad_addr_t   rd_addr;
  thi_pkg::quad_height_t corner;
  logic                  st_wr_en, st_rd_en;

  logic [FW:0]        fsum_nxt;
  logic               lower_nxt;
  logic [FW:0]        w1_nxt, w2_nxt, w3_nxt;
  logic signed [16:0] d1_nxt, d2_nxt, d3_nxt;
  logic signed [18:0] q1_nxt, q2_nxt, q3_nxt;
  logic signed [20:0] hsum_nxt;
  logic [HW-1:0]      hsat_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_extent_r <= thi_pkg::HALF_EXTENT_RST;
      grid_scale_r  <= thi_pkg::GRID_SCALE_RST;
      grid_points_r <= thi_pkg::GRID_POINTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thi_pkg::REG_HALF_EXTENT: half_extent_r <= cfg_wdata[thi_pkg::HALF_EXT_W-1:0];
        thi_pkg::REG_GRID_SCALE:  grid_scale_r  <= cfg_wdata[thi_pkg::SCALE_W-1:0];
        thi_pkg::REG_GRID_POINTS: grid_points_r <= cfg_wdata[thi_pkg::POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_points_r < 9'd2) begin
      pts = PW'(2);
    end else if (32'(grid_points_r) > 32'(GRID_POINTS)) begin
      pts = PW'(GRID_POINTS);
    end else begin
      pts = PW'(grid_points_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r && (s5_op_r == thi_pkg::OP_QUERY);
      s7_valid_r  <= s6_valid_r;
      out_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_op;
      s1_lidx_r <= in_load_index;
      s1_lhgt_r <= in_load_height;
      s1_wx_r   <= in_world_x;
      s1_wz_r   <= in_world_z;
    end
  end

  always_comb begin
    tx_nxt  = {s1_wx_r[31], s1_wx_r} + $signed({2'b00, half_extent_r});
    tz_nxt  = {s1_wz_r[31], s1_wz_r} + $signed({2'b00, half_extent_r});
    ntx_nxt = -tx_nxt;
    ntz_nxt = -tz_nxt;
  end

  always_ff @(posedge clk) begin
    s2_op_r   <= s1_op_r;
    s2_lidx_r <= s1_lidx_r;
    s2_lhgt_r <= s1_lhgt_r;
    s2_negx_r <= tx_nxt[32];
    s2_negz_r <= tz_nxt[32];
    s2_magx_r <= tx_nxt[32] ? ntx_nxt[31:0] : tx_nxt[31:0];
    s2_magz_r <= tz_nxt[32] ? ntz_nxt[31:0] : tz_nxt[31:0];
  end

  always_comb begin
    px_nxt = 64'(s2_magx_r) * 64'(grid_scale_r);
    pz_nxt = 64'(s2_magz_r) * 64'(grid_scale_r);
  end

  always_ff @(posedge clk) begin
    s3_op_r   <= s2_op_r;
    s3_lidx_r <= s2_lidx_r;
    s3_lhgt_r <= s2_lhgt_r;
    s3_gx_r   <= px_nxt[63:16];
    s3_gz_r   <= pz_nxt[63:16];
    s3_offx_r <= s2_negx_r && (grid_scale_r != '0);
    s3_offz_r <= s2_negz_r && (grid_scale_r != '0);
  end

  always_comb begin
    onx_nxt = !s3_offx_r && (s3_gx_r[47:16] < 32'(pts) - 32'd1);
    onz_nxt = !s3_offz_r && (s3_gz_r[47:16] < 32'(pts) - 32'd1);
  end

  always_ff @(posedge clk) begin
    s4_op_r   <= s3_op_r;
    s4_lidx_r <= s3_lidx_r;
    s4_lhgt_r <= s3_lhgt_r;
    s4_on_r   <= onx_nxt && onz_nxt;
    s4_cx_r   <= s3_gx_r[16 +: CW];
    s4_cz_r   <= s3_gz_r[16 +: CW];
    s4_fx_r   <= s3_gx_r[FW-1:0];
    s4_fz_r   <= s3_gz_r[FW-1:0];
  end

  assign base_nxt = 32'(s4_cx_r) * 32'(pts) + 32'(s4_cz_r);

  always_ff @(posedge clk) begin
    s5_op_r   <= s4_op_r;
    s5_lidx_r <= s4_lidx_r;
    s5_lhgt_r <= s4_lhgt_r;
    s5_on_r   <= s4_on_r;
    s5_base_r <= base_nxt[AW-1:0];
    s5_fx_r   <= s4_fx_r;
    s5_fz_r   <= s4_fz_r;
  end

  assign st_wr_en    = s5_valid_r && (s5_op_r == thi_pkg::OP_LOAD);
  assign st_rd_en    = s5_valid_r && (s5_op_r == thi_pkg::OP_QUERY);
  assign rd_addr.a00 = s5_base_r;
  assign rd_addr.a10 = s5_base_r + AW'(pts);
  assign rd_addr.a01 = s5_base_r + AW'(1);
  assign rd_addr.a11 = s5_base_r + AW'(pts) + AW'(1);

  thi_height_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (s5_lidx_r),
    .wr_data (s5_lhgt_r),
    .rd_en   (st_rd_en),
    .rd_addr (rd_addr),
    .rd_data (corner)
  );

  always_ff @(posedge clk) begin
    s6_on_r <= s5_on_r;
    s6_fx_r <= s5_fx_r;
    s6_fz_r <= s5_fz_r;
  end

  always_comb begin
    fsum_nxt  = {1'b0, s6_fx_r} + {1'b0, s6_fz_r};
    lower_nxt = (fsum_nxt <= thi_pkg::ONE_Q16);
    if (lower_nxt) begin
      w1_nxt = {1'b0, s6_fx_r};
      w2_nxt = {1'b0, s6_fz_r};
      w3_nxt = '0;
      d1_nxt = $signed({1'b0, corner.h10}) - $signed({1'b0, corner.h00});
      d2_nxt = $signed({1'b0, corner.h01}) - $signed({1'b0, corner.h00});
      d3_nxt = '0;
    end else begin
      w1_nxt = thi_pkg::ONE_Q16 - {1'b0, s6_fz_r};
      w2_nxt = fsum_nxt - thi_pkg::ONE_Q16;
      w3_nxt = thi_pkg::ONE_Q16 - {1'b0, s6_fx_r};
      d1_nxt = $signed({1'b0, corner.h10});
      d2_nxt = $signed({1'b0, corner.h11});
      d3_nxt = $signed({1'b0, corner.h01});
    end
  end

  always_ff @(posedge clk) begin
    s7_on_r   <= s6_on_r;
    s7_base_r <= lower_nxt ? corner.h00 : '0;
    s7_p1_r   <= 35'($signed({1'b0, w1_nxt})) * 35'(d1_nxt);
    s7_p2_r   <= 35'($signed({1'b0, w2_nxt})) * 35'(d2_nxt);
    s7_p3_r   <= 35'($signed({1'b0, w3_nxt})) * 35'(d3_nxt);
  end

  always_comb begin
    q1_nxt   = s7_p1_r[34:16];
    q2_nxt   = s7_p2_r[34:16];
    q3_nxt   = s7_p3_r[34:16];
    hsum_nxt = $signed({5'b0, s7_base_r}) + 21'(q1_nxt) + 21'(q2_nxt) + 21'(q3_nxt);
    if (hsum_nxt < 0) begin
      hsat_nxt = '0;
    end else if (hsum_nxt > 21'sd65535) begin
      hsat_nxt = '1;
    end else begin
      hsat_nxt = hsum_nxt[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_on_r     <= s7_on_r;
    out_height_r <= s7_on_r ? hsat_nxt : '0;
  end

  assign out_valid          = out_valid_r;
  assign out_on_terrain     = out_on_r;
  assign out_terrain_height = out_height_r;

  a_query_gives_result : assert property (
    @(posedge clk) disable iff (!rst_n)
    (accept && in_op == thi_pkg::OP_QUERY) |-> ##LAT out_valid)
    else $error("query item produced no result");

  a_load_gives_none : assert property (
    @(posedge clk) disable iff (!rst_n)
    (accept && in_op == thi_pkg::OP_LOAD) |-> ##LAT !out_valid)
    else $error("load item produced a result");

  a_off_is_zero : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_on_terrain) |-> (out_terrain_height == '0))
    else $error("off-terrain result carries a nonzero height");

  a_cell_in_range : assert property (
    @(posedge clk) disable iff (!rst_n)
    (s4_valid_r && s4_on_r) |->
      ((32'(s4_cx_r) + 32'd1 < 32'(pts)) && (32'(s4_cz_r) + 32'd1 < 32'(pts))))
    else $error("on-grid cell lies past the last cell");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terrain height interpolator. A driver feeds load
// and query items from a queue, a mirror of the height table and registers
// predicts each query, and a monitor checks every result strobe against the
// oldest prediction. Queries only touch cells whose corners have been loaded.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int    CYCLE_LIMIT = 200000;
  localparam int    DRAIN_WAIT  = 12;
  localparam int    PHASE_ITEMS = 80;
  localparam int    PTS_MAX     = thi_pkg::GRID_POINTS_DEF;
  localparam longint UNIT       = longint'(thi_pkg::ONE_Q16);

  typedef struct {
    logic                         op;
    logic [thi_pkg::ADDR_W-1:0]   index;
    logic [thi_pkg::HEIGHT_W-1:0] height;
    logic signed [31:0]           world_x;
    logic signed [31:0]           world_z;
  } terrain_item_t;

  typedef struct {
    logic [thi_pkg::HEIGHT_W-1:0] height;
    logic                         on_grid;
  } height_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = thi_pkg::OP_LOAD;
  logic [thi_pkg::ADDR_W-1:0] in_load_index = '0;
  logic [thi_pkg::HEIGHT_W-1:0] in_load_height = '0;
  logic signed [31:0] in_world_x = '0;
  logic signed [31:0] in_world_z = '0;
  logic out_valid;
  logic [thi_pkg::HEIGHT_W-1:0] out_terrain_height;
  logic out_on_terrain;
  logic cfg_we = 1'b0;
  logic [thi_pkg::CFG_IDX_W-1:0] cfg_index = thi_pkg::REG_HALF_EXTENT;
  logic [thi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [thi_pkg::HALF_EXT_W-1:0] half_ext_r = thi_pkg::HALF_EXTENT_RST;
  logic [thi_pkg::SCALE_W-1:0] scale_r = thi_pkg::GRID_SCALE_RST;
  logic [thi_pkg::POINTS_W-1:0] points_r = thi_pkg::GRID_POINTS_RST;

  logic [thi_pkg::HEIGHT_W-1:0] height_mirror [0:thi_pkg::STORE_DEPTH-1];
  bit loaded [0:thi_pkg::STORE_DEPTH-1];

  terrain_item_t pending[$];
  terrain_item_t cur;
  height_result_t heights_due[$];
  int unsigned send_gap_pct = 23;
  int unsigned win_lo = 0;
  int phase_items = 0;
  int mismatches = 0;
  int cycle_count = 0;

  terrain_height_interpolator_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_load_index(in_load_index),
    .in_load_height(in_load_height),
    .in_world_x(in_world_x),
    .in_world_z(in_world_z),
    .out_valid(out_valid),
    .out_terrain_height(out_terrain_height),
    .out_on_terrain(out_on_terrain),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned points_eff();
    int unsigned p;
    p = points_r;
    if (p < 2) p = 2;
    if (p > PTS_MAX) p = PTS_MAX;
    return p;
  endfunction

  function automatic bit map_axis(input logic signed [31:0] w, output int unsigned cell_idx,
                                  output logic [thi_pkg::FRAC_W-1:0] frac);
    longint t;
    logic [63:0] mag;
    logic [63:0] prod;
    t = longint'(w) + longint'(half_ext_r);
    mag = (t < 0) ? -t : t;
    prod = mag * 64'(scale_r);
    cell_idx = 0;
    frac = '0;
    if (t < 0 && prod != 0) return 1'b0;
    if (prod[63:32] >= 32'(points_eff() - 1)) return 1'b0;
    cell_idx = prod[63:32];
    frac = prod[31:16];
    return 1'b1;
  endfunction

  function automatic height_result_t surface_height_at(input logic signed [31:0] wx,
                                                        input logic signed [31:0] wz);
    height_result_t r;
    int unsigned cx, cz, p, base;
    logic [thi_pkg::FRAC_W-1:0] fx, fz;
    longint h00, h10, h01, h11, ux, uz, h;
    r.height = '0;
    r.on_grid = 1'b0;
    if (!(map_axis(wx, cx, fx) && map_axis(wz, cz, fz))) return r;
    p = points_eff();
    base = cx * p + cz;
    h00 = height_mirror[16'(base)];
    h10 = height_mirror[16'(base + p)];
    h01 = height_mirror[16'(base + 1)];
    h11 = height_mirror[16'(base + p + 1)];
    ux = fx;
    uz = fz;
    if (ux + uz <= UNIT) begin
      h = h00 + ((ux * (h10 - h00)) >>> 16) + ((uz * (h01 - h00)) >>> 16);
    end else begin
      h = (((UNIT - uz) * h10) >>> 16) + (((ux + uz - UNIT) * h11) >>> 16)
        + (((UNIT - ux) * h01) >>> 16);
    end
    if (h < 0) h = 0;
    if (h > 65535) h = 65535;
    r.height = 16'(h);
    r.on_grid = 1'b1;
    return r;
  endfunction

  // World coordinate whose grid coordinate lands at or just below the given cell and fraction.
  function automatic logic signed [31:0] aim_world(input int unsigned cell_idx,
                                                   input logic [thi_pkg::FRAC_W-1:0] frac);
    logic [63:0] target;
    logic [63:0] t;
    if (scale_r == 0) return $urandom;
    target = {cell_idx, frac, 16'($urandom)};
    t = target / 64'(scale_r);
    return 32'(longint'(t) - longint'(half_ext_r));
  endfunction

  function automatic logic signed [31:0] near_origin();
    longint d;
    d = longint'($urandom_range(0, 3)) - 2;
    return 32'(d - longint'(half_ext_r));
  endfunction

  function automatic int unsigned pick_cell();
    int unsigned p, span, r;
    p = points_eff();
    span = (p - 2 < 7) ? p - 2 : 7;
    r = $urandom_range(99);
    if (r < 80) return win_lo + $urandom_range(0, span);
    if (r < 92) return $urandom_range(0, p - 2);
    if (r < 96) return p - 2;
    return p - 1;
  endfunction

  task automatic push_load(input logic [thi_pkg::ADDR_W-1:0] index,
                           input logic [thi_pkg::HEIGHT_W-1:0] height);
    terrain_item_t item;
    loaded[index] = 1'b1;
    item = '{thi_pkg::OP_LOAD, index, height, $urandom, $urandom};
    pending.insert(pending.size(), item);
    phase_items++;
  endtask

  task automatic push_query(input logic signed [31:0] wx, input logic signed [31:0] wz);
    int unsigned cx, cz, p, base;
    logic [thi_pkg::FRAC_W-1:0] fx, fz;
    logic [thi_pkg::ADDR_W-1:0] corner [4];
    terrain_item_t item;
    if (map_axis(wx, cx, fx) && map_axis(wz, cz, fz)) begin
      p = points_eff();
      base = cx * p + cz;
      corner[0] = 16'(base);
      corner[1] = 16'(base + p);
      corner[2] = 16'(base + 1);
      corner[3] = 16'(base + p + 1);
      foreach (corner[k]) begin
        if (!loaded[corner[k]]) push_load(corner[k], 16'($urandom));
      end
    end
    item = '{thi_pkg::OP_QUERY, 16'($urandom), 16'($urandom), wx, wz};
    pending.insert(pending.size(), item);
    phase_items++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending.size() != 0 || start || heights_due.size() != 0);
  endtask

  task automatic write_reg(input logic [thi_pkg::CFG_IDX_W-1:0] index,
                           input logic [thi_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      thi_pkg::REG_HALF_EXTENT: half_ext_r = data[thi_pkg::HALF_EXT_W-1:0];
      thi_pkg::REG_GRID_SCALE:  scale_r = data[thi_pkg::SCALE_W-1:0];
      thi_pkg::REG_GRID_POINTS: points_r = data[thi_pkg::POINTS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] he, input logic [31:0] sc, input logic [31:0] pts);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    write_reg(thi_pkg::REG_HALF_EXTENT, he);
    write_reg(thi_pkg::REG_GRID_SCALE, sc);
    write_reg(thi_pkg::REG_GRID_POINTS, pts);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    logic next_start;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        if (cur.op == thi_pkg::OP_LOAD) begin
          height_mirror[cur.index] = cur.height;
        end else begin
          heights_due.insert(heights_due.size(), surface_height_at(cur.world_x, cur.world_z));
        end
        next_start = 1'b0;
      end
      if (!next_start && pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        cur = pending.pop_front();
        in_op <= cur.op;
        in_load_index <= cur.index;
        in_load_height <= cur.height;
        in_world_x <= cur.world_x;
        in_world_z <= cur.world_z;
        next_start = 1'b1;
      end
    end
    start <= next_start;
  end

  always @(posedge clk) begin
    height_result_t want;
    if (rst_n && out_valid) begin
      if (heights_due.size() == 0) begin
        report_mismatch($sformatf("result with no query pending: height %0d on_terrain %0b",
                                  out_terrain_height, out_on_terrain));
      end else begin
        want = heights_due.pop_front();
        if (out_terrain_height !== want.height) begin
          report_mismatch($sformatf("terrain_height got %0d, expected %0d",
                                    out_terrain_height, want.height));
        end
        if (out_on_terrain !== want.on_grid) begin
          report_mismatch($sformatf("on_terrain got %0b, expected %0b",
                                    out_on_terrain, want.on_grid));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned p, span, r;
    logic [31:0] he, sc, pts;
    bit paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: field extremes, grid corners and off-grid positions.
    push_load(16'hFFFF, 16'hFFFF);
    push_load(16'h0000, 16'h0000);
    push_query(aim_world(0, 16'h0000), aim_world(0, 16'h0000));
    push_query(aim_world(254, 16'hFFFF), aim_world(254, 16'hFFFF));
    push_query(aim_world(255, 16'h0100), aim_world(3, 16'h1234));
    push_query(32'(-longint'(half_ext_r) - 1), aim_world(0, 16'h8000));
    push_query(32'sh8000_0000, 32'sh7FFF_FFFF);
    push_query(32'sh7FFF_FFFF, 32'sh8000_0000);

    // Unit scale makes the fractions exact, so both triangles and the diagonal are hit.
    set_config(32'd0, 32'h0001_0000, 32'd256);
    push_load(16'd773, 16'd1);
    push_load(16'd1029, 16'd0);
    push_load(16'd774, 16'd0);
    push_load(16'd1030, 16'd65535);
    push_query(32'sh0003_8000, 32'sh0005_8000);
    push_query(32'sh0003_8001, 32'sh0005_8000);
    push_query(32'sh0003_FFFF, 32'sh0005_FFFF);
    push_query(32'sh0003_0000, 32'sh0005_0000);
    push_query(32'sh0003_FFFF, 32'sh0005_0000);
    push_load(16'd0, 16'd65535);
    push_load(16'd1, 16'd65535);
    push_load(16'd256, 16'd65535);
    push_load(16'd257, 16'd65535);
    push_query(32'sh0000_4000, 32'sh0000_4000);
    push_query(32'sh0000_C000, 32'sh0000_C000);
    push_query(-32'sd1, 32'sh0000_4000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin he = 32'd0;           sc = 32'hFFFF_FFFF; pts = 32'd2;   end
        1: begin he = 32'hFFFF_FFFF;   sc = 32'd1;         pts = 32'd256; end
        2: begin he = 32'h0010_0000;   sc = 32'd5243;      pts = 32'd17;  end
        3: begin he = 32'h0003_0000;   sc = 32'd0;         pts = 32'd1;   end
        4: begin he = 32'h0040_0000;   sc = 32'h0001_0000; pts = 32'h1FF; end
        5: begin he = 32'h0001_0000;   sc = 32'h0002_0000; pts = 32'd3;   end
        6: begin he = 32'd6553600;     sc = 32'd83558;     pts = 32'd256; end
        default: begin he = $urandom;  sc = 32'h0001_8000; pts = 32'd0;   end
      endcase
      set_config(he, sc, pts);
      send_gap_pct = (ph < 3) ? 23 : (ph < 6) ? 83 : 0;
      p = points_eff();
      span = (p - 2 < 7) ? p - 2 : 7;
      win_lo = $urandom_range(0, p - 2 - span);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (ph == 4 && !paused && phase_items >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 15) begin
          push_load(16'($urandom), 16'($urandom));
        end else if (r < 65) begin
          push_query(aim_world(pick_cell(), 16'($urandom)),
                     aim_world(pick_cell(), 16'($urandom)));
        end else if (r < 80) begin
          if ($urandom_range(1)) push_query(near_origin(), aim_world(pick_cell(), 16'($urandom)));
          else push_query(aim_world(pick_cell(), 16'($urandom)), near_origin());
        end else begin
          push_query($urandom, $urandom);
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/thi_pkg.sv
hw/rtl/thi_height_store.sv
hw/rtl/terrain_height_interpolator_unit.sv
tb/sv/tb_top.sv
